// ===== hw/rtl/ccfr_pkg.sv =====
`timescale 1ns / 1ps
package ccfr_pkg;

    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_RESET  = 16'hFFFF;
    localparam logic [7:0]  BYTE_DELIM = 8'h00;
    localparam logic [7:0]  CODE_FULL  = 8'hFF;
    // msg_id + payload_len + seq + timestamp + crc
    localparam logic [3:0]  MIN_FRAME  = 4'd9;
    localparam logic [2:0]  HDR_BYTES  = 3'd7;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 80;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNCATED = 3'd1,
        ST_SHORT     = 3'd2,
        ST_LEN_ERR   = 3'd3,
        ST_CRC_ERR   = 3'd4
    } status_t;

    typedef enum logic {
        KIND_DATA = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [8:0]  byte_index;
        status_t     status;
        logic [7:0]  msg_id;
        logic [7:0]  payload_len;
        logic [7:0]  seq;
        logic [31:0] timestamp;
    } result_t;

    // crc-16-ccitt, msb first, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/cobs_crc_frame_receiver.sv =====
`timescale 1ns / 1ps
// each result is registered, in the skid entry when the output stalls
// throughput: one raw byte per cycle while the skid is empty, set by the cobs
//   step and byte-wide crc update, between input handshake and result register
// a skid entry behind the result register takes one more result under stall
// reset: rst_n asynchronous, active low; clears frame state, empties the output,
//   crc seed returns to 0xFFFF
module cobs_crc_frame_receiver #(
    parameter int COUNT_LIMIT = 511
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration: crc seed
    input  logic                              cfg_wr_en,
    input  logic [15:0]                       cfg_wr_data,
    // raw byte stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ccfr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] raw_byte
    // decoded results
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] data_byte, [16:8] byte_index, [19:17] status, [27:20] msg_id,
    // [35:28] payload_len, [43:36] seq, [75:44] timestamp, [79:76] zero
    output logic [ccfr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tuser    // [0] kind
);
    import ccfr_pkg::*;

    localparam int CW = $clog2(COUNT_LIMIT + 1);

    // configuration
    logic [15:0]   crc_seed_reg;

    // frame state
    logic [7:0]    group_left_reg,   group_left_next;
    logic          zero_pending_reg, zero_pending_next;
    logic          in_frame_reg,     in_frame_next;
    logic [CW-1:0] count_reg,        count_next;
    logic [15:0]   crc_reg,          crc_next;
    logic [7:0]    tail0_reg,        tail0_next;
    logic [7:0]    tail1_reg,        tail1_next;
    logic [55:0]   header_reg,       header_next;

    // output register and skid
    result_t       out_reg,  out_next;
    logic          out_valid_reg, out_valid_next;
    result_t       skid_reg, skid_next;
    logic          skid_valid_reg, skid_valid_next;

    // per-item work
    logic          accept;
    logic [7:0]    in_byte;
    logic          produced;
    result_t       res;
    logic          take;       // a decoded byte enters the frame
    logic [7:0]    dec_byte;
    // frame state after a possible start of frame
    logic [7:0]    gl_eff;
    logic          zp_eff;
    logic [CW-1:0] cnt_eff;
    logic [15:0]   crc_eff;
    logic [7:0]    t0_eff, t1_eff;
    logic [55:0]   hdr_eff;
    logic [8:0]    len_expect;
    logic [15:0]   rx_crc;
    status_t       verdict;
    logic          out_free;

    assign in_byte       = s_axis_tdata[7:0];
    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign len_expect = {1'b0, header_reg[15:8]} + 9'(MIN_FRAME);
    assign rx_crc     = {tail1_reg, tail0_reg};

    // verdict priority: owed literal bytes, short, length, then crc
    always_comb
    begin
        if (group_left_reg != 8'd0)
            verdict = ST_TRUNCATED;
        else if (count_reg < CW'(MIN_FRAME))
            verdict = ST_SHORT;
        else if (count_reg != CW'(len_expect))
            verdict = ST_LEN_ERR;
        else if (crc_reg != rx_crc)
            verdict = ST_CRC_ERR;
        else
            verdict = ST_OK;
    end

    always_comb
    begin
        // a first non-delimiter byte opens a fresh frame
        if (!in_frame_reg)
        begin
            gl_eff  = 8'd0;
            zp_eff  = 1'b0;
            cnt_eff = '0;
            crc_eff = crc_seed_reg;
            t0_eff  = 8'd0;
            t1_eff  = 8'd0;
            hdr_eff = '0;
        end
        else
        begin
            gl_eff  = group_left_reg;
            zp_eff  = zero_pending_reg;
            cnt_eff = count_reg;
            crc_eff = crc_reg;
            t0_eff  = tail0_reg;
            t1_eff  = tail1_reg;
            hdr_eff = header_reg;
        end

        group_left_next   = group_left_reg;
        zero_pending_next = zero_pending_reg;
        in_frame_next     = in_frame_reg;
        count_next        = count_reg;
        crc_next          = crc_reg;
        tail0_next        = tail0_reg;
        tail1_next        = tail1_reg;
        header_next       = header_reg;

        produced = 1'b0;
        take     = 1'b0;
        dec_byte = 8'd0;
        res      = '0;

        if (in_byte == BYTE_DELIM)
        begin
            // empty frames give nothing
            if (in_frame_reg)
            begin
                produced          = 1'b1;
                res.kind          = KIND_END;
                res.byte_index    = count_reg[8:0];
                res.status        = verdict;
                res.msg_id        = header_reg[7:0];
                res.payload_len   = header_reg[15:8];
                res.seq           = header_reg[23:16];
                res.timestamp     = header_reg[55:24];
                in_frame_next     = 1'b0;
                group_left_next   = 8'd0;
                zero_pending_next = 1'b0;
            end
        end
        else
        begin
            in_frame_next     = 1'b1;
            group_left_next   = gl_eff;
            zero_pending_next = zp_eff;
            count_next        = cnt_eff;
            crc_next          = crc_eff;
            tail0_next        = t0_eff;
            tail1_next        = t1_eff;
            header_next       = hdr_eff;
            if (gl_eff != 8'd0)
            begin
                // literal byte of the current group
                group_left_next = gl_eff - 8'd1;
                take            = 1'b1;
                dec_byte        = in_byte;
            end
            else
            begin
                // code byte; the previous short group implies a zero
                group_left_next   = in_byte - 8'd1;
                zero_pending_next = (in_byte != CODE_FULL);
                take              = zp_eff;
                dec_byte          = 8'd0;
            end

            if (take)
            begin
                produced       = 1'b1;
                res.kind       = KIND_DATA;
                res.data_byte  = dec_byte;
                res.byte_index = cnt_eff[8:0];
                for (int i = 0; i < 7; i++)
                begin
                    if (cnt_eff == CW'(i))
                        header_next[i*8 +: 8] = dec_byte;
                end
                // crc trails the stream by two bytes
                if (cnt_eff >= CW'(2))
                    crc_next = crc16_byte(crc_eff, t0_eff);
                tail0_next = t1_eff;
                tail1_next = dec_byte;
                // count holds at the limit
                if (cnt_eff < CW'(COUNT_LIMIT))
                    count_next = CW'(cnt_eff + 1'b1);
            end
        end
    end

    // two-entry output: result register in front, skid behind
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = res;
                out_valid_next = accept && produced;
            end
        end
        else if (accept && produced)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_seed_reg     <= CRC_RESET;
            group_left_reg   <= 8'd0;
            zero_pending_reg <= 1'b0;
            in_frame_reg     <= 1'b0;
            count_reg        <= '0;
            crc_reg          <= CRC_RESET;
            tail0_reg        <= 8'd0;
            tail1_reg        <= 8'd0;
            header_reg       <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                crc_seed_reg <= cfg_wr_data;
            if (accept)
            begin
                group_left_reg   <= group_left_next;
                zero_pending_reg <= zero_pending_next;
                in_frame_reg     <= in_frame_next;
                count_reg        <= count_next;
                crc_reg          <= crc_next;
                tail0_reg        <= tail0_next;
                tail1_reg        <= tail1_next;
                header_reg       <= header_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {4'b0000, out_reg.timestamp,
                            out_reg.seq, out_reg.payload_len, out_reg.msg_id,
                            out_reg.status, out_reg.byte_index, out_reg.data_byte};

`ifndef SYNTH
    // skid only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    // outside a frame no group is open and no zero is owed
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (group_left_reg == 8'd0 && !zero_pending_reg))
        else $error("group state left over outside a frame");

    // decoded count saturates at the limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(COUNT_LIMIT))
        else $error("decoded count ran past its limit");

    // a stalled result is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> out_valid_reg)
        else $error("stalled result lost");
`endif

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import ccfr_pkg::*;

    localparam int COUNT_MAX   = 511;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 180;

    // clock and the one reset pulse at the start
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // every block input starts at a known value
    logic                   cfg_wr_en     = 1'b0;
    logic [15:0]            cfg_wr_data   = 16'h0000;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;    // [7:0] raw_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [7:0] data_byte, [16:8] byte_index, [19:17] status, [27:20] msg_id,
    // [35:28] payload_len, [43:36] seq, [75:44] timestamp, [79:76] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;          // [0] kind

    cobs_crc_frame_receiver #(
        .COUNT_LIMIT(COUNT_MAX)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // raw bytes waiting for the driver, and the decoder results still owed
    logic [7:0] raw_byte_q[$];
    result_t    awaited_results[$];
    int         fail_count  = 0;
    int         cycle_count = 0;

    // shadow of the receiver: seed register and per-frame decode state
    logic [15:0] seed_shadow  = CRC_RESET;
    logic [7:0]  grp_left     = 8'h00;
    logic        zero_owed    = 1'b0;
    logic        framing      = 1'b0;
    logic [8:0]  dec_count    = 9'd0;
    logic [15:0] frame_crc    = CRC_RESET;
    logic [7:0]  tail_lo      = 8'h00;
    logic [7:0]  tail_hi      = 8'h00;
    logic [55:0] hdr_bytes    = 56'h0;

    // plain (decoded) frame under construction by the stimulus side
    logic [7:0] plain_buf[$];
    int         phase_count;

    // crc-16-ccitt, msb first, bit-serial form
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                   input logic [7:0] d);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[15] ^ d[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // one decoded byte: data result, header capture, crc lags two bytes
    task automatic emit_decoded(input logic [7:0] b);
        result_t r;
        r            = '0;
        r.kind       = KIND_DATA;
        r.data_byte  = b;
        r.byte_index = dec_count;
        if (dec_count < HDR_BYTES)
            hdr_bytes[dec_count * 8 +: 8] = b;
        if (dec_count >= 2)
            frame_crc = crc_ccitt_step(frame_crc, tail_lo);
        tail_lo = tail_hi;
        tail_hi = b;
        if (dec_count < COUNT_MAX)
            dec_count = dec_count + 9'd1;
        awaited_results = {awaited_results, r};
    endtask

    // advance the shadow decoder by one accepted raw byte
    task automatic cobs_decode_step(input logic [7:0] b);
        result_t     r;
        status_t     st;
        logic [7:0]  plen;
        logic [15:0] rx_crc;
        logic        emit;
        if (b == BYTE_DELIM)
        begin
            // delimiter outside a frame is an empty frame: nothing comes out
            if (framing)
            begin
                plen   = hdr_bytes[15:8];
                rx_crc = {tail_hi, tail_lo};
                // verdict priority: owed literals, short, length, crc
                if (grp_left != 8'h00)
                    st = ST_TRUNCATED;
                else if (dec_count < MIN_FRAME)
                    st = ST_SHORT;
                else if (int'(dec_count) != int'(MIN_FRAME) + int'(plen))
                    st = ST_LEN_ERR;
                else if (frame_crc != rx_crc)
                    st = ST_CRC_ERR;
                else
                    st = ST_OK;
                r             = '0;
                r.kind        = KIND_END;
                r.byte_index  = dec_count;
                r.status      = st;
                r.msg_id      = hdr_bytes[7:0];
                r.payload_len = plen;
                r.seq         = hdr_bytes[23:16];
                r.timestamp   = hdr_bytes[55:24];
                awaited_results = {awaited_results, r};
                framing   = 1'b0;
                grp_left  = 8'h00;
                // a zero still owed at the delimiter is dropped
                zero_owed = 1'b0;
            end
        end
        else
        begin
            // first byte of a frame: seed is sampled here
            if (!framing)
            begin
                framing   = 1'b1;
                grp_left  = 8'h00;
                zero_owed = 1'b0;
                dec_count = 9'd0;
                frame_crc = seed_shadow;
                tail_lo   = 8'h00;
                tail_hi   = 8'h00;
                hdr_bytes = 56'h0;
            end
            if (grp_left != 8'h00)
            begin
                grp_left = grp_left - 8'd1;
                emit_decoded(b);
            end
            else
            begin
                // code byte: the previous short group's implied zero comes out now
                emit      = zero_owed;
                grp_left  = b - 8'd1;
                zero_owed = (b < CODE_FULL);
                if (emit)
                    emit_decoded(8'h00);
            end
        end
    endtask

    task automatic push_raw(input logic [7:0] b);
        raw_byte_q = {raw_byte_q, b};
        phase_count++;
    endtask

    // little-endian crc over what is in the plain buffer
    task automatic append_crc();
        logic [15:0] c;
        c = seed_shadow;
        foreach (plain_buf[i])
            c = crc_ccitt_step(c, plain_buf[i]);
        plain_buf = {plain_buf, c[7:0]};
        plain_buf = {plain_buf, c[15:8]};
    endtask

    // header, payload with some zeros, crc
    task automatic build_frame(input logic [7:0] plen_field, input int n_payload);
        plain_buf.delete();
        plain_buf = {plain_buf, 8'($urandom_range(0, 255))};
        plain_buf = {plain_buf, plen_field};
        for (int i = 0; i < 5; i++)
            plain_buf = {plain_buf, 8'($urandom_range(0, 255))};
        for (int i = 0; i < n_payload; i++)
            plain_buf = {plain_buf, (($urandom_range(0, 5) == 0) ? 8'h00 :
                                     8'($urandom_range(1, 255)))};
        append_crc();
    endtask

    // cobs-encode the plain buffer, optionally cut the tail, then delimit
    task automatic cobs_push(input int drop);
        logic [7:0] enc[$];
        int         code_pos;
        logic [7:0] code;
        code_pos = 0;
        enc = {enc, 8'h00};
        code = 8'd1;
        foreach (plain_buf[i])
        begin
            if (plain_buf[i] == 8'h00)
            begin
                enc[code_pos] = code;
                code_pos      = enc.size();
                enc = {enc, 8'h00};
                code = 8'd1;
            end
            else
            begin
                enc = {enc, plain_buf[i]};
                code = code + 8'd1;
                // full 254-byte group: code 0xff, no implied zero
                if (code == CODE_FULL)
                begin
                    enc[code_pos] = code;
                    code_pos      = enc.size();
                    enc = {enc, 8'h00};
                    code = 8'd1;
                end
            end
        end
        enc[code_pos] = code;
        for (int k = 0; k < drop && enc.size() > 1; k++)
            void'(enc.pop_back());
        foreach (enc[i])
            push_raw(enc[i]);
        push_raw(BYTE_DELIM);
    endtask

    // idle means nothing queued, nothing on either bus, nothing owed, for a while
    task automatic wait_drained();
        int quiet;
        quiet = 0;
        while (quiet < 4)
        begin
            @(posedge clk);
            if (raw_byte_q.size() != 0 || s_axis_tvalid || m_axis_tvalid ||
                awaited_results.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    task automatic write_seed(input logic [15:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        seed_shadow = v;
    endtask

    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        result_t want;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none actual kind %0d tdata %h",
                     $time, m_axis_tuser, m_axis_tdata);
            fail_count++;
        end
        else
        begin
            want = awaited_results.pop_front();
            compare_field("kind",        want.kind,        m_axis_tuser);
            compare_field("data_byte",   want.data_byte,   m_axis_tdata[7:0]);
            compare_field("byte_index",  want.byte_index,  m_axis_tdata[16:8]);
            compare_field("status",      want.status,      m_axis_tdata[19:17]);
            compare_field("msg_id",      want.msg_id,      m_axis_tdata[27:20]);
            compare_field("payload_len", want.payload_len, m_axis_tdata[35:28]);
            compare_field("seq",         want.seq,         m_axis_tdata[43:36]);
            compare_field("timestamp",   want.timestamp,   m_axis_tdata[75:44]);
        end
    endtask

    // driver: a random idle gap after each item, with runs of back-to-back items
    int   send_gap  = 0;
    logic send_calm = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                cobs_decode_step(s_axis_tdata);
            // free to present the next item unless one is held by backpressure
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (raw_byte_q.size() > 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= raw_byte_q.pop_front();
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_gap = send_calm ? 0 : $urandom_range(0, 15);
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: a random stall after each result, counted while a result waits
    int   recv_gap  = 0;
    logic recv_calm = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result();
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                recv_gap = recv_calm ? 0 : $urandom_range(0, 15);
            end
            else if (recv_gap > 0 && m_axis_tvalid)
            begin
                recv_gap--;
            end
            m_axis_tready <= (recv_gap == 0);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus and phases
    initial
    begin
        logic [15:0] phase_seed;
        int          pick;
        int          n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset seed
        phase_count = 0;
        // empty frame
        push_raw(BYTE_DELIM);
        // well-formed frame with zero payload and extreme header bytes
        plain_buf.delete();
        plain_buf = {plain_buf, 8'h00};
        plain_buf = {plain_buf, 8'h00};
        plain_buf = {plain_buf, 8'hFF};
        plain_buf = {plain_buf, 8'h00};
        plain_buf = {plain_buf, 8'hFF};
        plain_buf = {plain_buf, 8'h00};
        plain_buf = {plain_buf, 8'hFF};
        append_crc();
        cobs_push(0);
        // short frame, header partly missing, trailing implied zero dropped
        push_raw(8'h03);
        push_raw(8'h11);
        push_raw(8'h22);
        push_raw(BYTE_DELIM);
        // literals still owed at the delimiter
        push_raw(8'h05);
        push_raw(8'h01);
        push_raw(8'h02);
        push_raw(BYTE_DELIM);
        // implied zero released by the next code byte
        push_raw(8'h01);
        push_raw(8'h01);
        push_raw(BYTE_DELIM);
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: phase_seed = 16'h0000;
                1: phase_seed = 16'hFFFF;
                3: phase_seed = 16'h1D0F;
                default: phase_seed = 16'($urandom_range(0, 65535));
            endcase
            write_seed(phase_seed);
            phase_count = 0;

            // one long frame drives the byte count into saturation
            if (phase == 2)
            begin
                plain_buf.delete();
                for (int i = 0; i < 540; i++)
                    plain_buf = {plain_buf, (($urandom_range(0, 49) == 0) ? 8'h00 :
                                             8'($urandom_range(1, 255)))};
                cobs_push(0);
            end

            while (phase_count < PHASE_ITEMS)
            begin
                // stray delimiters between frames are ignored by the block
                if ($urandom_range(0, 9) == 0)
                    raw_byte_q = {raw_byte_q, BYTE_DELIM};
                pick = $urandom_range(0, 10);
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) :
                    $urandom_range(0, 12);
                if (pick <= 5)
                begin
                    build_frame(8'(n), n);
                    cobs_push(0);
                end
                else if (pick == 6)
                begin
                    // declared length disagrees with the payload
                    build_frame(8'($urandom_range(0, 255)), n);
                    cobs_push(0);
                end
                else if (pick == 7)
                begin
                    // one byte damaged after the crc was computed
                    build_frame(8'(n), n);
                    plain_buf[$urandom_range(0, plain_buf.size() - 1)] ^=
                        8'($urandom_range(1, 255));
                    cobs_push(0);
                end
                else if (pick == 8)
                begin
                    // encoded stream cut short before the delimiter
                    build_frame(8'(n), n);
                    cobs_push($urandom_range(1, 3));
                end
                else if (pick == 9)
                begin
                    // fewer bytes than a header and crc
                    plain_buf.delete();
                    for (int i = 0; i < $urandom_range(1, 8); i++)
                        plain_buf = {plain_buf, 8'($urandom_range(0, 255))};
                    cobs_push(0);
                end
                else
                begin
                    // raw noise, then a delimiter
                    for (int i = 0; i < $urandom_range(1, 12); i++)
                        push_raw(8'($urandom_range(0, 255)));
                    push_raw(BYTE_DELIM);
                end
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ccfr_pkg.sv
hw/rtl/cobs_crc_frame_receiver.sv
bench/tb.sv
